/* sv/sbr_pkg.sv */
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and constants of the streaming byte replace-all block.
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam int NEEDLE_MAX  = 16;
  localparam int REPLACE_MAX = 16;
  localparam int QDEPTH      = 4;

  localparam int NCNT_W = $clog2(NEEDLE_MAX + 1);
  localparam int RCNT_W = $clog2(REPLACE_MAX + 1);
  localparam int NIDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] FUNC_START  = 3'd0;
  localparam logic [2:0] FUNC_NEEDLE = 3'd1;
  localparam logic [2:0] FUNC_REPL   = 3'd2;
  localparam logic [2:0] FUNC_HAY    = 3'd3;
  localparam logic [2:0] FUNC_END    = 3'd4;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_NEEDLE,
    CMD_REPL,
    CMD_HAY,
    CMD_END
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REPL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } item_t;

endpackage

/* sv/sbr_front.sv */
// ----------------------------------------------------------------------------
// sbr_front
// Accepts input beats, classifies the function code and queues commands.
// ----------------------------------------------------------------------------
module sbr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  logic [2:0]    func,
  input  logic [7:0]    data_byte,
  output sbr_pkg::item_t head,
  output logic          head_valid,
  input  logic          pop
);
  import sbr_pkg::*;

  item_t             q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cmd;
  logic              known;
  logic              push;
  logic              do_pop;

  always_comb begin
    known = 1'b1;
    case (func)
      FUNC_START:  cmd = CMD_START;
      FUNC_NEEDLE: cmd = CMD_NEEDLE;
      FUNC_REPL:   cmd = CMD_REPL;
      FUNC_HAY:    cmd = CMD_HAY;
      FUNC_END:    cmd = CMD_END;
      default: begin
        cmd   = CMD_START;
        known = 1'b0;
      end
    endcase
  end

  assign item_ready = (count != QCNT_W'(QDEPTH));
  assign push       = item_valid && item_ready && known;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{cmd: cmd, data: data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/sbr_back.sv */
// ----------------------------------------------------------------------------
// sbr_back
// Executes queued commands: holds needle, replacement and window, and
// drives the result register.
// ----------------------------------------------------------------------------
module sbr_back (
  input  logic           clk,
  input  logic           rst,
  input  sbr_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_ready,
  output logic [7:0]     out_byte,
  output logic           byte_valid,
  output logic           last,
  output logic           overflow
);
  import sbr_pkg::*;

  state_t            state, state_next;
  logic [7:0]        needle [NEEDLE_MAX];
  logic [7:0]        needle_next [NEEDLE_MAX];
  logic [7:0]        replace [REPLACE_MAX];
  logic [7:0]        replace_next [REPLACE_MAX];
  logic [7:0]        window [NEEDLE_MAX];
  logic [7:0]        window_next [NEEDLE_MAX];
  logic [7:0]        shifted [NEEDLE_MAX];
  logic [NCNT_W-1:0] needle_count, needle_count_next;
  logic [RCNT_W-1:0] replace_count, replace_count_next;
  logic [NCNT_W-1:0] window_count, window_count_next;
  logic              overflow_seen, overflow_seen_next;
  logic [RIDX_W-1:0] rep_idx, rep_idx_next;
  logic              out_free;
  logic              load;
  logic [7:0]        out_byte_next;
  logic              byte_valid_next, last_next, overflow_next;
  logic              match;

  assign out_free = !result_valid || result_ready;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      if (NCNT_W'(i) < needle_count && window[i] != needle[i]) begin
        match = 1'b0;
      end
    end
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      shifted[i] = (i < NEEDLE_MAX - 1) ? window[(i + 1) % NEEDLE_MAX] : window[i];
    end
  end

  always_comb begin
    state_next         = state;
    needle_next        = needle;
    replace_next       = replace;
    window_next        = window;
    needle_count_next  = needle_count;
    replace_count_next = replace_count;
    window_count_next  = window_count;
    overflow_seen_next = overflow_seen;
    rep_idx_next       = rep_idx;
    pop                = 1'b0;
    load               = 1'b0;
    out_byte_next      = out_byte;
    byte_valid_next    = byte_valid;
    last_next          = last;
    overflow_next      = overflow;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          case (head.cmd)
            CMD_START: begin
              pop                = 1'b1;
              needle_count_next  = '0;
              replace_count_next = '0;
              window_count_next  = '0;
              overflow_seen_next = 1'b0;
            end
            CMD_NEEDLE: begin
              pop = 1'b1;
              if (needle_count < NCNT_W'(NEEDLE_MAX)) begin
                needle_next[needle_count[NIDX_W-1:0]] = head.data;
                needle_count_next = needle_count + 1'b1;
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            CMD_REPL: begin
              pop = 1'b1;
              if (replace_count < RCNT_W'(REPLACE_MAX)) begin
                replace_next[replace_count[RIDX_W-1:0]] = head.data;
                replace_count_next = replace_count + 1'b1;
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            CMD_HAY: begin
              if (needle_count == '0) begin
                if (out_free) begin
                  pop             = 1'b1;
                  load            = 1'b1;
                  out_byte_next   = head.data;
                  byte_valid_next = 1'b1;
                  last_next       = 1'b0;
                  overflow_next   = 1'b0;
                end
              end else begin
                pop = 1'b1;
                if (window_count < NCNT_W'(NEEDLE_MAX)) begin
                  window_next[window_count[NIDX_W-1:0]] = head.data;
                  window_count_next = window_count + 1'b1;
                end
                state_next = ST_CHECK;
              end
            end
            CMD_END: begin
              pop        = 1'b1;
              state_next = ST_FLUSH;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_CHECK: begin
        if (window_count >= needle_count) begin
          if (match) begin
            if (replace_count == '0) begin
              window_count_next = '0;
              state_next        = ST_IDLE;
            end else begin
              rep_idx_next = '0;
              state_next   = ST_REPL;
            end
          end else if (out_free) begin
            load              = 1'b1;
            out_byte_next     = window[0];
            byte_valid_next   = 1'b1;
            last_next         = 1'b0;
            overflow_next     = 1'b0;
            window_next       = shifted;
            window_count_next = window_count - 1'b1;
            state_next        = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_REPL: begin
        if (out_free) begin
          load            = 1'b1;
          out_byte_next   = replace[rep_idx];
          byte_valid_next = 1'b1;
          last_next       = 1'b0;
          overflow_next   = 1'b0;
          if ({1'b0, rep_idx} + 1'b1 == replace_count) begin
            window_count_next = '0;
            state_next        = ST_IDLE;
          end else begin
            rep_idx_next = rep_idx + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          load = 1'b1;
          if (window_count == '0) begin
            out_byte_next   = 8'd0;
            byte_valid_next = 1'b0;
            last_next       = 1'b1;
            overflow_next   = overflow_seen;
            state_next      = ST_IDLE;
          end else begin
            out_byte_next     = window[0];
            byte_valid_next   = 1'b1;
            last_next         = (window_count == NCNT_W'(1));
            overflow_next     = (window_count == NCNT_W'(1)) && overflow_seen;
            window_next       = shifted;
            window_count_next = window_count - 1'b1;
            if (window_count == NCNT_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    needle  <= needle_next;
    replace <= replace_next;
    window  <= window_next;
    if (load) begin
      out_byte   <= out_byte_next;
      byte_valid <= byte_valid_next;
      last       <= last_next;
      overflow   <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      needle_count  <= '0;
      replace_count <= '0;
      window_count  <= '0;
      overflow_seen <= 1'b0;
      rep_idx       <= '0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      needle_count  <= needle_count_next;
      replace_count <= replace_count_next;
      window_count  <= window_count_next;
      overflow_seen <= overflow_seen_next;
      rep_idx       <= rep_idx_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/stream_byte_replace_all_unit.sv */
// ----------------------------------------------------------------------------
// stream_byte_replace_all_unit
// Streaming replace-all of a needle by a replacement in a byte string.
// ----------------------------------------------------------------------------
//  channel  handshake                   payload
//  item     item_valid / item_ready     func, data_byte
//  result   result_valid / result_ready out_byte, byte_valid, last, overflow
//
//  Start, needle and replacement beats are handled by the back end in idle;
//  unused codes are dropped at the front and never reach the back end.
//  Haystack beat: passed straight out with an empty needle, else loaded into
//  the window and compared, then each replacement byte is sent on a match.
//  End beat: each window byte is flushed in order, or one empty last beat.
//  A 4-entry command queue lets the front accept while the back end works.
//  Reset clears counts, queue and result valid; stores need no reset.
// ----------------------------------------------------------------------------
module stream_byte_replace_all_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [2:0] func,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last,
  output logic       overflow
);
  import sbr_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;

  sbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .func       (func),
    .data_byte  (data_byte),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  sbr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .overflow     (overflow)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_valid |-> last)
    else $error("empty result beat without last");

  a_overflow_on_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> last)
    else $error("overflow flagged on a beat that is not last");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

/* test/stream_byte_replace_all_unit_tb.sv */
// ----------------------------------------------------------------------------
// stream_byte_replace_all_unit_tb
// Self-checking bench for the streaming byte replace-all block. A queue of
// rows (start, needle, replacement, haystack, end) plus noise and broken rows
// feeds a bursty driver. A receiver with its own stall pattern, including one
// long hold-off, drains the results. Each accepted beat is checked against a
// predictor that tracks needle, replacement and sliding window state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stream_byte_replace_all_unit_tb;
  import sbr_pkg::*;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam int BEATS_PER_ITEM = 16;
  localparam int ITEM_TARGET    = 170;
  localparam int HOLD_AT        = 60;
  localparam int HOLD_CYCLES    = 250;

  typedef struct {
    logic [2:0] fn;
    logic [7:0] db;
  } row_item_t;

  typedef struct {
    logic [7:0] ob;
    logic       bv;
    logic       lst;
    logic       ovf;
  } out_beat_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_CADENCE} rdy_mode_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [2:0] func = FUNC_START;
  logic [7:0] data_byte = 8'h00;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic       overflow;

  stream_byte_replace_all_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .overflow     (overflow)
  );

  row_item_t items_to_send[$];
  out_beat_t expected_beats[$];
  int        errors = 0;
  int        items_taken = 0;
  int        items_queued = 0;
  logic      item_taken = 1'b0;

  logic [7:0] ndl_bytes[NEEDLE_MAX];
  int         ndl_len = 0;
  logic [7:0] rpl_bytes[REPLACE_MAX];
  int         rpl_len = 0;
  logic [7:0] win_bytes[NEEDLE_MAX];
  int         win_len = 0;
  logic       drop_flag = 1'b0;

  function automatic void predict_replace(input logic [2:0] fn, input logic [7:0] db);
    out_beat_t beats[$];
    out_beat_t b;
    logic      hit;
    int        i;
    b.lst = 1'b0;
    b.ovf = 1'b0;
    b.bv  = 1'b1;
    case (fn)
      FUNC_START: begin
        ndl_len   = 0;
        rpl_len   = 0;
        win_len   = 0;
        drop_flag = 1'b0;
      end
      FUNC_NEEDLE: begin
        if (ndl_len < NEEDLE_MAX) begin
          ndl_bytes[ndl_len] = db;
          ndl_len++;
        end else begin
          drop_flag = 1'b1;
        end
      end
      FUNC_REPL: begin
        if (rpl_len < REPLACE_MAX) begin
          rpl_bytes[rpl_len] = db;
          rpl_len++;
        end else begin
          drop_flag = 1'b1;
        end
      end
      FUNC_HAY: begin
        if (ndl_len == 0) begin
          b.ob = db;
          beats.push_back(b);
        end else begin
          if (win_len < NEEDLE_MAX) begin
            win_bytes[win_len] = db;
            win_len++;
          end
          if (win_len >= ndl_len) begin
            hit = 1'b1;
            for (i = 0; i < ndl_len; i++)
              if (win_bytes[i] != ndl_bytes[i]) hit = 1'b0;
            if (hit) begin
              for (i = 0; i < rpl_len; i++) begin
                b.ob = rpl_bytes[i];
                beats.push_back(b);
              end
              win_len = 0;
            end else begin
              b.ob = win_bytes[0];
              beats.push_back(b);
              for (i = 1; i < win_len; i++) win_bytes[i - 1] = win_bytes[i];
              win_len--;
            end
          end
        end
      end
      FUNC_END: begin
        for (i = 0; i < win_len; i++) begin
          b.ob = win_bytes[i];
          beats.push_back(b);
        end
        win_len = 0;
        if (beats.size() == 0) begin
          b.ob = 8'h00;
          b.bv = 1'b0;
          beats.push_back(b);
        end
      end
      default: ;
    endcase
    while (beats.size() > BEATS_PER_ITEM) void'(beats.pop_back());
    if (fn == FUNC_END) begin
      beats[beats.size() - 1].lst = 1'b1;
      beats[beats.size() - 1].ovf = drop_flag;
    end
    foreach (beats[k]) expected_beats.push_back(beats[k]);
  endfunction

  task automatic add_item(input logic [2:0] fn, input logic [7:0] db);
    row_item_t it;
    it.fn = fn;
    it.db = db;
    items_to_send.push_back(it);
    if (fn <= FUNC_END) items_queued++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL stream_byte_replace_all_unit");
    $finish;
  end

  // driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : drive_items
    row_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        nxt = items_to_send.pop_front();
        item_valid <= 1'b1;
        func       <= nxt.fn;
        data_byte  <= nxt.db;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  rdy_mode_t rdy_mode = RDY_ALWAYS;
  int        mode_left = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  int        cadence = 0;

  always @(negedge clk) begin : drive_ready
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      cadence++;
      case (rdy_mode)
        RDY_ALWAYS:  result_ready <= 1'b1;
        RDY_COIN:    result_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE:  result_ready <= ($urandom_range(0, 3) == 0);
        default:     result_ready <= (cadence % 3 != 0);
      endcase
    end
  end

  // monitor: predict on accepted items, check accepted results
  always @(posedge clk) begin : watch
    out_beat_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_valid && item_ready;
      if (item_valid && item_ready) begin
        predict_replace(func, data_byte);
        items_taken++;
      end
      if (result_valid && result_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t unexpected beat: out_byte %h byte_valid %b last %b overflow %b",
                   $time, out_byte, byte_valid, last, overflow);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (out_byte !== want.ob || byte_valid !== want.bv || last !== want.lst ||
              overflow !== want.ovf) begin
            $display("%0t mismatch: expected out_byte %h byte_valid %b last %b overflow %b",
                     $time, want.ob, want.bv, want.lst, want.ovf);
            $display("%0t           actual   out_byte %h byte_valid %b last %b overflow %b",
                     $time, out_byte, byte_valid, last, overflow);
            errors++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] nb[$];
    logic [7:0] a0;
    logic [7:0] a1;
    int         r;
    int         nlen;
    int         rlen;
    int         hlen;
    int         k;

    // empty needle passes bytes, then an empty end
    add_item(FUNC_HAY, 8'h00);
    add_item(FUNC_HAY, 8'hFF);
    add_item(FUNC_END, 8'h00);
    // match, mismatch and a flushed window
    add_item(FUNC_START, 8'hFF);
    add_item(FUNC_NEEDLE, 8'h5A);
    add_item(FUNC_NEEDLE, 8'hA5);
    add_item(FUNC_REPL, 8'h00);
    add_item(FUNC_REPL, 8'hFF);
    add_item(FUNC_HAY, 8'h5A);
    add_item(FUNC_HAY, 8'hA5);
    add_item(FUNC_HAY, 8'h5A);
    add_item(FUNC_HAY, 8'h33);
    add_item(FUNC_END, 8'hFF);
    // haystack after end reuses the stored needle
    add_item(FUNC_HAY, 8'h5A);
    add_item(FUNC_HAY, 8'hA5);
    add_item(FUNC_END, 8'h00);
    add_item(FUNC_SPARE_LO, 8'hC3);
    add_item(FUNC_SPARE_HI, 8'h3C);
    // empty replacement deletes; late needle byte lengthens the needle
    add_item(FUNC_START, 8'h00);
    add_item(FUNC_NEEDLE, 8'h11);
    add_item(FUNC_HAY, 8'h11);
    add_item(FUNC_NEEDLE, 8'h22);
    add_item(FUNC_HAY, 8'h11);
    add_item(FUNC_HAY, 8'h22);
    add_item(FUNC_END, 8'h00);

    while (items_queued < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_item(3'($urandom_range(0, 7)), 8'($urandom));
      end else if (r < 13) begin
        repeat ($urandom_range(1, 4))
          add_item(3'($urandom_range(FUNC_NEEDLE, FUNC_END)), 8'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8)       nlen = 0;
        else if (r < 80) nlen = $urandom_range(1, 3);
        else if (r < 94) nlen = $urandom_range(4, NEEDLE_MAX);
        else             nlen = $urandom_range(NEEDLE_MAX + 1, NEEDLE_MAX + 2);
        r = $urandom_range(0, 99);
        if (r < 70)      rlen = $urandom_range(0, 3);
        else if (r < 92) rlen = $urandom_range(4, REPLACE_MAX - 1);
        else if (r < 96) rlen = REPLACE_MAX;
        else             rlen = $urandom_range(REPLACE_MAX + 1, REPLACE_MAX + 3);
        a0 = 8'($urandom);
        a1 = 8'($urandom);
        nb.delete();
        add_item(FUNC_START, 8'($urandom));
        for (k = 0; k < nlen; k++) begin
          r = $urandom_range(0, 9);
          nb.push_back(r < 5 ? a0 : (r < 9 ? a1 : 8'($urandom)));
          add_item(FUNC_NEEDLE, nb[k]);
        end
        while (nb.size() > NEEDLE_MAX) void'(nb.pop_back());
        for (k = 0; k < rlen; k++) add_item(FUNC_REPL, 8'($urandom));
        hlen = $urandom_range(0, 12);
        k = 0;
        while (k < hlen) begin
          r = $urandom_range(0, 99);
          if (r < 35 && nb.size() > 0) begin
            foreach (nb[j]) add_item(FUNC_HAY, nb[j]);
            k += nb.size();
          end else begin
            add_item(FUNC_HAY, r < 65 ? a0 : (r < 90 ? a1 : 8'($urandom)));
            k++;
          end
        end
        add_item(FUNC_END, 8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) add_item(FUNC_HAY, $urandom_range(0, 1) ? a0 : a1);
          add_item(FUNC_END, 8'($urandom));
        end
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_to_send.size() > 0 || item_valid) @(posedge clk);
    while (expected_beats.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("PASS stream_byte_replace_all_unit");
    end else begin
      $display("FAIL stream_byte_replace_all_unit");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sbr_pkg.sv
sv/sbr_front.sv
sv/sbr_back.sv
sv/stream_byte_replace_all_unit.sv
test/stream_byte_replace_all_unit_tb.sv
